@@ rtl/ctre_pkg.sv @@
// Shared types and constants of the color transform record encoder.
package ctre_pkg;

    localparam int NumTerms   = 4;              // terms per group
    localparam int NumLanes   = 2 * NumTerms;   // multiply lanes, then add lanes
    localparam int NbitsW     = 4;              // width of the size field
    localparam int MaxNbits   = (1 << NbitsW) - 1;
    localparam int MultIdentity = 256;
    localparam int HdrBits    = 2 + NbitsW;     // two flags and the size field
    localparam int RecBits    = 128;            // 16 bytes, enough for the longest record
    localparam int ShiftW     = 7;              // bit offsets inside the record
    localparam int CntW       = 5;              // byte count, 1 to 16

    // Per-lane finding: term equals its group identity, and its signed width.
    typedef struct packed {
        logic              ident;
        logic [NbitsW-1:0] sbits;
    } lane_res_t;

    // Merged control for one record.
    typedef struct packed {
        logic              has_add;
        logic              mult_present;
        logic [NbitsW-1:0] nbits;
    } rec_ctrl_t;

endpackage

@@ rtl/ctre_lane.sv @@
// One lane: identity check and clamped signed width of a single term.
module ctre_lane #(
    parameter int TERM_WIDTH = 16,
    parameter bit IS_MULT    = 1'b0
) (
    input  logic [TERM_WIDTH-1:0] term,
    output ctre_pkg::lane_res_t   res
);
    import ctre_pkg::*;

    logic [TERM_WIDTH-1:0] mag;
    logic [NbitsW-1:0]     sbits;

    always_comb begin
        // negative terms count bits on the complement
        mag   = term[TERM_WIDTH-1] ? ~term : term;
        sbits = NbitsW'(1);
        for (int i = 0; i < TERM_WIDTH - 1; i++) begin
            if (mag[i]) begin
                sbits = (i + 2 > MaxNbits) ? NbitsW'(MaxNbits) : NbitsW'(i + 2);
            end
        end
        res.sbits = sbits;
        // compare as signed values: narrow terms can never equal the identity
        res.ident = IS_MULT ? ($signed(term) == MultIdentity) : (term == '0);
    end

endmodule

@@ rtl/ctre_merge.sv @@
// Merge stage: group flags from all lanes, common field width from the lanes of present groups.
module ctre_merge #(
    parameter int TERM_WIDTH = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  ctre_pkg::lane_res_t [ctre_pkg::NumLanes-1:0]  in_lanes,
    input  logic [ctre_pkg::NumLanes-1:0][TERM_WIDTH-1:0] in_terms,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output ctre_pkg::rec_ctrl_t                           out_ctrl,
    output logic [ctre_pkg::NumLanes-1:0][TERM_WIDTH-1:0] out_terms
);
    import ctre_pkg::*;

    logic                                 valid_reg, valid_next;
    rec_ctrl_t                            ctrl_reg, ctrl_next;
    logic [NumLanes-1:0][TERM_WIDTH-1:0]  terms_reg;
    logic                                 take;

    always_comb begin
        ctrl_next = '0;
        for (int k = 0; k < NumTerms; k++) begin
            if (!in_lanes[k].ident)            ctrl_next.mult_present = 1'b1;
            if (!in_lanes[NumTerms + k].ident) ctrl_next.has_add      = 1'b1;
        end
        for (int k = 0; k < NumTerms; k++) begin
            if (ctrl_next.mult_present && in_lanes[k].sbits > ctrl_next.nbits) begin
                ctrl_next.nbits = in_lanes[k].sbits;
            end
            if (ctrl_next.has_add && in_lanes[NumTerms + k].sbits > ctrl_next.nbits) begin
                ctrl_next.nbits = in_lanes[NumTerms + k].sbits;
            end
        end
    end

    assign in_ready   = !valid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign valid_next = take ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            ctrl_reg  <= ctrl_next;
            terms_reg <= in_terms;
        end
    end

    assign out_valid = valid_reg;
    assign out_ctrl  = ctrl_reg;
    assign out_terms = terms_reg;

endmodule

@@ rtl/ctre_pack.sv @@
// Pack stage: header and present terms placed MSB first in a 128-bit record.
module ctre_pack #(
    parameter int TERM_WIDTH = 16
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          in_valid,
    output logic                                          in_ready,
    input  ctre_pkg::rec_ctrl_t                           in_ctrl,
    input  logic [ctre_pkg::NumLanes-1:0][TERM_WIDTH-1:0] in_terms,
    output logic                                          out_valid,
    input  logic                                          out_ready,
    output logic [ctre_pkg::RecBits-1:0]                  out_rec,
    output logic [ctre_pkg::CntW-1:0]                     out_nbytes
);
    import ctre_pkg::*;

    logic                 valid_reg, valid_next;
    logic [RecBits-1:0]   rec_reg, rec_next;
    logic [CntW-1:0]      nbytes_reg, nbytes_next;
    logic [MaxNbits-1:0]  fmask;
    logic [MaxNbits-1:0]  tbits;
    logic [ShiftW-1:0]    shamt;
    logic [ShiftW-1:0]    nrec_bits;
    logic [1:0]           ngroups;
    logic [3:0]           slot;
    logic                 take;

    always_comb begin
        fmask    = ~({MaxNbits{1'b1}} << in_ctrl.nbits);
        rec_next = '0;
        rec_next[RecBits-1 -: HdrBits] = {in_ctrl.has_add, in_ctrl.mult_present,
                                          in_ctrl.nbits};
        for (int j = 0; j < NumLanes; j++) begin
            // slot in the record: add terms follow the multiply group when present
            if (j < NumTerms) begin
                slot = 4'(j);
            end else begin
                slot = in_ctrl.mult_present ? 4'(j) : 4'(j - NumTerms);
            end
            tbits = MaxNbits'(in_terms[j]) & fmask;
            shamt = ShiftW'(RecBits - HdrBits)
                  - (ShiftW'(slot) + ShiftW'(1)) * ShiftW'(in_ctrl.nbits);
            if ((j < NumTerms) ? in_ctrl.mult_present : in_ctrl.has_add) begin
                rec_next = rec_next | (RecBits'(tbits) << shamt);
            end
        end
        ngroups     = 2'(in_ctrl.mult_present) + 2'(in_ctrl.has_add);
        nrec_bits   = ShiftW'(HdrBits)
                    + ShiftW'(ngroups) * ShiftW'(NumTerms) * ShiftW'(in_ctrl.nbits);
        nbytes_next = CntW'((8'(nrec_bits) + 8'd7) >> 3);
    end

    assign in_ready   = !valid_reg || out_ready;
    assign take       = in_valid && in_ready;
    assign valid_next = take ? 1'b1 : (out_ready ? 1'b0 : valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take) begin
            rec_reg    <= rec_next;
            nbytes_reg <= nbytes_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_rec    = rec_reg;
    assign out_nbytes = nbytes_reg;

endmodule

@@ rtl/ctre_serializer.sv @@
// Byte serializer: shifts a packed record out one byte per transaction.
module ctre_serializer (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [ctre_pkg::RecBits-1:0] in_rec,
    input  logic [ctre_pkg::CntW-1:0]    in_nbytes,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [7:0]                   m_tdata,
    output logic                         m_tlast
);
    import ctre_pkg::*;

    logic               valid_reg, valid_next;
    logic [RecBits-1:0] sh_reg, sh_next;
    logic [CntW-1:0]    left_reg, left_next;
    logic               last;
    logic               load;

    assign last     = (left_reg == CntW'(1));
    assign in_ready = !valid_reg || (m_tready && last);
    assign load     = in_valid && in_ready;

    always_comb begin
        valid_next = valid_reg;
        sh_next    = sh_reg;
        left_next  = left_reg;
        if (load) begin
            valid_next = 1'b1;
            sh_next    = in_rec;
            left_next  = in_nbytes;
        end else if (valid_reg && m_tready) begin
            if (last) begin
                valid_next = 1'b0;
            end
            sh_next   = sh_reg << 8;
            left_next = left_reg - CntW'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            left_reg  <= '0;
        end else begin
            valid_reg <= valid_next;
            left_reg  <= left_next;
        end
    end

    always_ff @(posedge aclk) begin
        sh_reg <= sh_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = sh_reg[RecBits-1 -: 8];
    assign m_tlast  = last;

endmodule

@@ rtl/color_transform_record_encoder.sv @@
// Top level of the color transform record encoder.
//
// Slave channel: one transaction carries a color transform, eight signed
// terms of TERM_WIDTH bits (four 8.8 multiply terms, four add offsets).
// Master channel: the encoded record, one byte per transaction, bits MSB
// first, tlast on the final byte. A record is 1 to 16 bytes: two presence
// flags, a 4-bit field width, then the present terms, zero padded.
// Pipeline: lane stage (8 lanes find identity and signed width per term),
// merge stage (flags, max width), pack stage (128-bit record), serializer.
// First byte leaves after the lane, merge, pack and serializer registers.
// Throughput is set by the serializer: one byte per cycle while m_tready
// stays high; inputs are taken back to back while earlier records are
// still in the pipe, up to three records buffered.
// A stall on the master side holds the current byte and fills the stages
// ahead of it; s_tready drops once all are full.
// Reset (aresetn low, synchronous) empties every stage; no record is lost
// or duplicated after it since no state carries from one record to the next.
module color_transform_record_encoder #(
    parameter int TERM_WIDTH = 16
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    // mult_red, mult_green, mult_blue, mult_alpha,
    // add_red, add_green, add_blue, add_alpha (TERM_WIDTH bits each)
    input  logic [8*TERM_WIDTH-1:0] s_tdata,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // out_byte
    output logic [7:0]              m_tdata,
    // last_byte
    output logic                    m_tlast
);
    import ctre_pkg::*;

    // lane stage
    logic [NumLanes-1:0][TERM_WIDTH-1:0] in_terms;
    lane_res_t [NumLanes-1:0]            lane_res;
    logic                                a_valid_reg, a_valid_next;
    lane_res_t [NumLanes-1:0]            a_lanes_reg;
    logic [NumLanes-1:0][TERM_WIDTH-1:0] a_terms_reg;
    logic                                a_take;

    // merge -> pack
    logic                                b_ready;
    logic                                b_valid;
    rec_ctrl_t                           b_ctrl;
    logic [NumLanes-1:0][TERM_WIDTH-1:0] b_terms;
    logic                                c_ready;

    // pack -> serializer
    logic                                c_valid;
    logic [RecBits-1:0]                  c_rec;
    logic [CntW-1:0]                     c_nbytes;
    logic                                d_ready;

    assign in_terms = s_tdata;

    for (genvar g = 0; g < NumLanes; g++) begin : g_lane
        ctre_lane #(
            .TERM_WIDTH (TERM_WIDTH),
            .IS_MULT    (g < NumTerms)
        ) u_lane (
            .term (in_terms[g]),
            .res  (lane_res[g])
        );
    end

    assign s_tready     = !a_valid_reg || b_ready;
    assign a_take       = s_tvalid && s_tready;
    assign a_valid_next = a_take ? 1'b1 : (b_ready ? 1'b0 : a_valid_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else begin
            a_valid_reg <= a_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_take) begin
            a_lanes_reg <= lane_res;
            a_terms_reg <= in_terms;
        end
    end

    ctre_merge #(
        .TERM_WIDTH (TERM_WIDTH)
    ) u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (a_valid_reg),
        .in_ready  (b_ready),
        .in_lanes  (a_lanes_reg),
        .in_terms  (a_terms_reg),
        .out_valid (b_valid),
        .out_ready (c_ready),
        .out_ctrl  (b_ctrl),
        .out_terms (b_terms)
    );

    ctre_pack #(
        .TERM_WIDTH (TERM_WIDTH)
    ) u_pack (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (b_valid),
        .in_ready   (c_ready),
        .in_ctrl    (b_ctrl),
        .in_terms   (b_terms),
        .out_valid  (c_valid),
        .out_ready  (d_ready),
        .out_rec    (c_rec),
        .out_nbytes (c_nbytes)
    );

    ctre_serializer u_ser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (c_valid),
        .in_ready  (d_ready),
        .in_rec    (c_rec),
        .in_nbytes (c_nbytes),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench of the color transform record encoder.
module testbench;
    import ctre_pkg::*;

    localparam int TermW      = 16;
    localparam int CycleLimit = 200000;
    localparam int HoldCycles = 300;
    localparam int DrainWait  = 32;
    localparam int RandItems  = 320;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } rec_byte_t;

    // Holds the bytes still owed by the block and predicts new ones.
    class record_scoreboard;
        rec_byte_t expected_bytes[$];
        int        fail_count;

        function new();
            fail_count = 0;
        endfunction

        // Smallest two's complement width of one term.
        static function int signed_width(logic [TermW-1:0] t);
            logic [TermW-1:0] r;
            int               n;
            r = t[TermW-1] ? ~t : t;
            n = 0;
            while (r != 0) begin
                r = r >> 1;
                n++;
            end
            return n + 1;
        endfunction

        // Appends the low n bits of v, MSB first.
        static function void put_bits(inout logic [RecBits-1:0] rec, inout int pos,
                                      input logic [TermW-1:0] v, input int n);
            for (int k = n - 1; k >= 0; k--) begin
                if (pos < RecBits) begin
                    rec[RecBits-1-pos] = v[k];
                    pos++;
                end
            end
        endfunction

        // Accepted transform: work out its record and queue the bytes.
        function void note_transform(logic [NumLanes*TermW-1:0] d);
            logic signed [TermW-1:0] term[NumLanes];
            logic [RecBits-1:0]      rec;
            int                      pos, nbits, nbytes;
            bit                      mult_present, has_add;
            rec_byte_t               b;
            mult_present = 0;
            has_add      = 0;
            nbits        = 0;
            for (int i = 0; i < NumLanes; i++)
                term[i] = d[i*TermW +: TermW];
            for (int i = 0; i < NumTerms; i++) begin
                if (term[i] != MultIdentity)
                    mult_present = 1;
                if (term[NumTerms+i] != 0)
                    has_add = 1;
            end
            for (int i = 0; i < NumTerms; i++) begin
                if (mult_present && signed_width(term[i]) > nbits)
                    nbits = signed_width(term[i]);
                if (has_add && signed_width(term[NumTerms+i]) > nbits)
                    nbits = signed_width(term[NumTerms+i]);
            end
            if (nbits > MaxNbits)
                nbits = MaxNbits;
            rec = '0;
            pos = 0;
            put_bits(rec, pos, TermW'(has_add), 1);
            put_bits(rec, pos, TermW'(mult_present), 1);
            put_bits(rec, pos, TermW'(nbits), NbitsW);
            if (mult_present)
                for (int i = 0; i < NumTerms; i++)
                    put_bits(rec, pos, term[i], nbits);
            if (has_add)
                for (int i = 0; i < NumTerms; i++)
                    put_bits(rec, pos, term[NumTerms+i], nbits);
            nbytes = (pos + 7) / 8;
            for (int i = 0; i < nbytes; i++) begin
                b.data = rec[RecBits-1-8*i -: 8];
                b.last = (i == nbytes - 1);
                expected_bytes.push_back(b);
            end
        endfunction

        // Accepted output byte: compare with the oldest expected one.
        function void check_byte(logic [7:0] data, logic last);
            rec_byte_t e;
            if (expected_bytes.size() == 0) begin
                $error("unexpected byte: out_byte actual %h last_byte actual %b",
                       data, last);
                fail_count++;
                return;
            end
            e = expected_bytes.pop_front();
            if (data !== e.data) begin
                $error("out_byte expected %h actual %h", e.data, data);
                fail_count++;
            end
            if (last !== e.last) begin
                $error("last_byte expected %b actual %b", e.last, last);
                fail_count++;
            end
        endfunction

        function int pending();
            return expected_bytes.size();
        endfunction
    endclass

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        s_tvalid;
    logic                        s_tready;
    logic [NumLanes*TermW-1:0]   s_tdata;
    logic                        m_tvalid;
    logic                        m_tready;
    logic [7:0]                  m_tdata;
    logic                        m_tlast;

    record_scoreboard sb = new();

    logic gaps_on;          // random idling on both sides
    int   hold_asked;       // bumped by the sender to request a long stall
    int   hold_served;
    int   hold_left;
    int   cycles;

    color_transform_record_encoder #(
        .TERM_WIDTH(TermW)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // Watchdog.
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CycleLimit) begin
            $display("simulation failed");
            $finish;
        end
    end

    // Both monitors sample the pre-edge values of the handshake.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_transform(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            sb.check_byte(m_tdata, m_tlast);
    end

    // Receiver: random back-pressure, plus one long hold-off on request
    // so the pipe fills and s_tready has to drop.
    always @(posedge aclk) begin
        if (hold_left > 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_asked != hold_served) begin
            hold_served <= hold_asked;
            hold_left   <= HoldCycles;
            m_tready    <= 1'b0;
        end else begin
            m_tready <= !(gaps_on && $urandom_range(99) < 33);
        end
    end

    function automatic logic [NumLanes*TermW-1:0] make_cxform(
        int mr, int mg, int mb, int ma, int ar, int ag, int ab, int aa);
        return {TermW'(aa), TermW'(ab), TermW'(ag), TermW'(ar),
                TermW'(ma), TermW'(mb), TermW'(mg), TermW'(mr)};
    endfunction

    // Random term that fits in w bits signed.
    function automatic logic [TermW-1:0] rand_term(int w);
        logic [TermW-1:0] t;
        t = TermW'($urandom);
        t = t << (TermW - w);
        t = $signed(t) >>> (TermW - w);
        return t;
    endfunction

    // Offer one transform; returns once it has been accepted.
    task automatic send_transform(input logic [NumLanes*TermW-1:0] d);
        while (gaps_on && $urandom_range(99) < 33) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= d;
        do
            @(posedge aclk);
        while (!s_tready);
    endtask

    initial begin
        logic [TermW-1:0]          t[NumLanes];
        logic [NumLanes*TermW-1:0] d;
        int                        kind, w;
        aresetn    <= 1'b0;
        s_tvalid   <= 1'b0;
        s_tdata    <= '0;
        m_tready   <= 1'b0;
        gaps_on    <= 1'b1;
        hold_asked <= 0;
        hold_served <= 0;
        hold_left  <= 0;
        cycles     <= 0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part.
        // Both groups at identity: single zero byte.
        send_transform(make_cxform(256, 256, 256, 256, 0, 0, 0, 0));
        // Add group only.
        send_transform(make_cxform(256, 256, 256, 256, 1, 0, 0, 0));
        send_transform(make_cxform(256, 256, 256, 256, 0, 0, 0, -1));
        send_transform(make_cxform(256, 256, 256, 256, -32768, 0, 0, 0));
        // Multiply group only; identity values inside a present group count.
        send_transform(make_cxform(255, 256, 256, 256, 0, 0, 0, 0));
        send_transform(make_cxform(256, 256, 256, 257, 0, 0, 0, 0));
        send_transform(make_cxform(0, 0, 0, 0, 0, 0, 0, 0));
        send_transform(make_cxform(-256, 256, 0, 1, 0, 0, 0, 0));
        // Width over 15 gets clamped; low bits kept.
        send_transform(make_cxform(-32768, -32768, -32768, -32768,
                                   -32768, -32768, -32768, -32768));
        send_transform(make_cxform(32767, 32767, 32767, 32767,
                                   32767, 32767, 32767, 32767));
        send_transform(make_cxform(256, 256, 256, 256, 16384, 0, 0, 0));
        // Width exactly 15.
        send_transform(make_cxform(16383, -16384, 256, 256, 0, 0, 0, 0));
        // Narrowest width, with both groups and with the add group only.
        send_transform(make_cxform(-1, -1, -1, -1, -1, -1, -1, -1));
        send_transform(make_cxform(256, 256, 256, 256, -1, -1, -1, -1));
        // Alternating patterns, padding of the last byte.
        send_transform(make_cxform('h5555, 'haaaa, 'h5555, 'haaaa,
                                   'haaaa, 'h5555, 'haaaa, 'h5555));
        send_transform(make_cxform(1, 2, 3, 4, 5, 6, 7, 8));
        send_transform(make_cxform(256, 256, 256, 256, 3, -4, 0, 1));

        // Random part: first stretch with no idling at all.
        gaps_on <= 1'b0;
        for (int n = 0; n < RandItems; n++) begin
            if (n == 80)
                gaps_on <= 1'b1;
            if (n == 200)
                hold_asked <= hold_asked + 1;
            kind = $urandom_range(9);
            w    = (kind >= 7) ? TermW : $urandom_range(1, TermW);
            for (int i = 0; i < NumLanes; i++)
                t[i] = rand_term(w);
            for (int i = 0; i < NumTerms; i++) begin
                // sparse identity terms inside otherwise present groups
                if (kind >= 4 && kind <= 6 && $urandom_range(3) == 0)
                    t[i] = TermW'(MultIdentity);
                if (kind >= 4 && kind <= 6 && $urandom_range(3) == 0)
                    t[NumTerms+i] = '0;
                if (kind == 0 || kind == 2)
                    t[i] = TermW'(MultIdentity);
                if (kind == 1 || kind == 2)
                    t[NumTerms+i] = '0;
            end
            for (int i = 0; i < NumLanes; i++)
                d[i*TermW +: TermW] = t[i];
            send_transform(d);
        end
        s_tvalid <= 1'b0;
        // let the monitor note the final transaction first
        @(posedge aclk);

        while (sb.pending() != 0)
            @(posedge aclk);
        repeat (DrainWait) @(posedge aclk);

        if (sb.fail_count == 0 && sb.pending() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
